>>> design/assert_macros.svh
// Assertion helpers used by central_mass_velocity_kick
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_ON_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> design/cmvk_pkg.sv
package cmvk_pkg;

   // default fraction width of positions and velocities
   localparam int FRAC_BITS_DEF = 16;
   // unit vectors and direction terms are Q30
   localparam int Q30 = 30;
   // restoring square root of a 64-bit value: one result bit per step
   localparam int SQRT_STEPS = 32;
   // unit-vector division: quotient bits 30..0
   localparam int UDIV_STEPS = 31;

   // register indexes (address bit 2)
   localparam logic REG_MASS = 1'b0;
   localparam logic REG_MODE = 1'b1;

   typedef struct packed {
      logic [63:0] n;
      logic [63:0] root;
   } sqrt_type;

   typedef struct packed {
      logic        qb;
      logic [32:0] rem;
   } div_type;

   // magnitude of a 32-bit signed value (-2^31 gives 2^31)
   function automatic logic [31:0] abs32(logic signed [31:0] c);
      return c[31] ? 32'(-c) : 32'(c);
   endfunction

   function automatic logic [31:0] max3(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      logic [31:0] m;
      m = (a > b) ? a : b;
      return (c > m) ? c : m;
   endfunction

   // normalizing shift: -1 when the largest magnitude is 2^31, else the
   // least k with m*2^k >= 2^30
   function automatic logic signed [5:0] norm_shift(logic [31:0] m);
      logic [4:0] pos;
      pos = 5'd30;
      for (int i = 0; i < 31; i++) begin
         if (m[i]) begin
            pos = 5'(i);
         end
      end
      if (m[31]) begin
         return -6'sd1;
      end
      return 6'sd30 - $signed({1'b0, pos});
   endfunction

   function automatic logic signed [31:0] norm_apply(logic signed [31:0] c,
                                                     logic signed [5:0] k);
      if (k < 0) begin
         return c >>> 1;
      end
      return c <<< k[4:0];
   endfunction

   // one step of the bitwise integer square root
   function automatic sqrt_type sqrt_step(sqrt_type x, logic [63:0] bitv);
      sqrt_type   y;
      logic [64:0] trial;
      trial = {1'b0, x.root} + {1'b0, bitv};
      if ({1'b0, x.n} >= trial) begin
         y.n    = x.n - trial[63:0];
         y.root = (x.root >> 1) + bitv;
      end else begin
         y.n    = x.n;
         y.root = x.root >> 1;
      end
      return y;
   endfunction

   // one step of restoring division; remainder comes back pre-shifted
   function automatic div_type div_step(logic [32:0] rem, logic [31:0] den);
      div_type     y;
      logic [32:0] r;
      if (rem >= {1'b0, den}) begin
         r    = rem - {1'b0, den};
         y.qb = 1'b1;
      end else begin
         r    = rem;
         y.qb = 1'b0;
      end
      y.rem = {r[31:0], 1'b0};
      return y;
   endfunction

endpackage

>>> design/central_mass_velocity_kick.sv
// Central mass velocity kick: for each particle (position r, velocity v,
// signed fixed point with FRAC_BITS fraction bits) the block forms the kick
// (r x v) x r * sqrt(M/|r|) / (|r|^2 |v|) and returns it as the new velocity
// (add_mode 0) or adds it to v (add_mode 1), saturating to 32 bits. A zero
// r or v returns v unchanged with degenerate set. The block is one linear
// pipeline that takes a request every cycle while it is not held; its
// stages include the bit-per-stage square roots (two times 32 stages)
// and the bit-per-stage division of the mass by |r| (2*FRAC_BITS + 31
// stages). A stalled response holds the pipe only once the last stage
// is also full, so requests keep entering while a response waits.
`include "assert_macros.svh"

module central_mass_velocity_kick #(
   parameter int FRAC_BITS = cmvk_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic               req_last_body,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_new_vel_x,
   output logic signed [31:0] rsp_new_vel_y,
   output logic signed [31:0] rsp_new_vel_z,
   output logic               rsp_degenerate,
   output logic               rsp_saturated,
   output logic               rsp_last_out,
   // register port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // mass quotient bits and their container (at least 65 bits for saturation)
   localparam int QW = 2 * FRAC_BITS + 31;
   localparam int QX = (QW > 65) ? QW : 65;

   // stage map
   localparam int ST_IN   = 0;
   localparam int ST_MAG  = 1;
   localparam int ST_SHK  = 2;
   localparam int ST_NORM = 3;
   localparam int ST_SQR  = 4;
   localparam int ST_SUM  = 5;
   localparam int ST_RT0  = 6;
   localparam int ST_DIV0 = ST_RT0 + cmvk_pkg::SQRT_STEPS;
   localparam int ST_DS0  = ST_DIV0 + 1;
   localparam int ST_SGN  = ST_DS0 + QW;
   localparam int ST_DP   = ST_SGN + 1;
   localparam int ST_DOT  = ST_DP + 1;
   localparam int ST_RD   = ST_DOT + 1;
   localparam int ST_U    = ST_RD + 1;
   localparam int ST_QI   = ST_U + 1;
   localparam int ST_QS0  = ST_QI + 1;
   localparam int ST_KM   = ST_QS0 + cmvk_pkg::SQRT_STEPS;
   localparam int NS      = ST_KM + 1;

   typedef struct {
      logic                 last;
      logic                 degen;
      logic signed [31:0]   pos [3];
      logic signed [31:0]   vel [3];
      logic [31:0]          mag_r;
      logic [31:0]          mag_v;
      logic signed [5:0]    k_r;
      logic signed [5:0]    k_v;
      logic signed [31:0]   a_r [3];
      logic signed [31:0]   a_v [3];
      logic signed [64:0]   prd_r [3];
      logic signed [64:0]   prd_v [3];
      cmvk_pkg::sqrt_type   sq [2];
      logic [32:0]          urem_r [3];
      logic [32:0]          urem_v [3];
      logic [30:0]          uq_r [3];
      logic [30:0]          uq_v [3];
      logic [32:0]          mrem;
      logic [QX-1:0]        mq;
      logic signed [31:0]   rh [3];
      logic signed [31:0]   vh [3];
      logic signed [31:0]   dot;
      logic signed [31:0]   u [3];
      logic [63:0]          q;
   } item_type;

   // configuration registers
   logic [30:0] central_mass_ff, central_mass_in;
   logic        add_mode_ff, add_mode_in;
   logic        csr_write;

   // pipeline
   item_type    item_ff [NS];
   item_type    item_in [NS];
   logic [NS-1:0] vld_ff, vld_in;
   logic        adv;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] res_ff [3];
   logic signed [31:0] res_in [3];
   logic               degen_ff, degen_in;
   logic               sat_ff, sat_in;
   logic               last_ff, last_in;
   logic               load;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      central_mass_in = central_mass_ff;
      add_mode_in     = add_mode_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            cmvk_pkg::REG_MASS: central_mass_in = csr_pwdata[30:0];
            cmvk_pkg::REG_MODE: add_mode_in     = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         central_mass_ff <= 31'd65536;
         add_mode_ff     <= 1'b0;
      end else begin
         central_mass_ff <= central_mass_in;
         add_mode_ff     <= add_mode_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         cmvk_pkg::REG_MASS: csr_prdata = {1'b0, central_mass_ff};
         cmvk_pkg::REG_MODE: csr_prdata = {31'd0, add_mode_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   // ---------------- pipeline control ----------------
   // whole pipe moves unless the last stage is full and its result is blocked
   assign adv       = !vld_ff[NS-1] || !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign vld_in    = {vld_ff[NS-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- pipeline stages ----------------
   for (genvar s = 0; s < NS; s++) begin : g_stage
      if (s == ST_IN) begin : g_in
         always_comb begin
            item_in[s]        = item_ff[s];
            item_in[s].pos[0] = req_pos_x;
            item_in[s].pos[1] = req_pos_y;
            item_in[s].pos[2] = req_pos_z;
            item_in[s].vel[0] = req_vel_x;
            item_in[s].vel[1] = req_vel_y;
            item_in[s].vel[2] = req_vel_z;
            item_in[s].last   = req_last_body;
         end
      end else if (s == ST_MAG) begin : g_mag
         // zero test and largest component magnitude
         always_comb begin
            item_in[s] = item_ff[s-1];
            item_in[s].degen =
               (item_ff[s-1].pos[0] == 0 && item_ff[s-1].pos[1] == 0 &&
                item_ff[s-1].pos[2] == 0) ||
               (item_ff[s-1].vel[0] == 0 && item_ff[s-1].vel[1] == 0 &&
                item_ff[s-1].vel[2] == 0);
            item_in[s].mag_r = cmvk_pkg::max3(cmvk_pkg::abs32(item_ff[s-1].pos[0]),
                                              cmvk_pkg::abs32(item_ff[s-1].pos[1]),
                                              cmvk_pkg::abs32(item_ff[s-1].pos[2]));
            item_in[s].mag_v = cmvk_pkg::max3(cmvk_pkg::abs32(item_ff[s-1].vel[0]),
                                              cmvk_pkg::abs32(item_ff[s-1].vel[1]),
                                              cmvk_pkg::abs32(item_ff[s-1].vel[2]));
         end
      end else if (s == ST_SHK) begin : g_shk
         always_comb begin
            item_in[s]     = item_ff[s-1];
            item_in[s].k_r = cmvk_pkg::norm_shift(item_ff[s-1].mag_r);
            item_in[s].k_v = cmvk_pkg::norm_shift(item_ff[s-1].mag_v);
         end
      end else if (s == ST_NORM) begin : g_norm
         always_comb begin
            item_in[s] = item_ff[s-1];
            for (int i = 0; i < 3; i++) begin
               item_in[s].a_r[i] = cmvk_pkg::norm_apply(item_ff[s-1].pos[i],
                                                        item_ff[s-1].k_r);
               item_in[s].a_v[i] = cmvk_pkg::norm_apply(item_ff[s-1].vel[i],
                                                        item_ff[s-1].k_v);
            end
         end
      end else if (s == ST_SQR) begin : g_sqr
         always_comb begin
            item_in[s] = item_ff[s-1];
            for (int i = 0; i < 3; i++) begin
               item_in[s].prd_r[i] = 65'(item_ff[s-1].a_r[i]) * 65'(item_ff[s-1].a_r[i]);
               item_in[s].prd_v[i] = 65'(item_ff[s-1].a_v[i]) * 65'(item_ff[s-1].a_v[i]);
            end
         end
      end else if (s == ST_SUM) begin : g_sum
         // sums of squares feed the square roots
         always_comb begin
            item_in[s] = item_ff[s-1];
            item_in[s].sq[0].n = 64'(item_ff[s-1].prd_r[0]) + 64'(item_ff[s-1].prd_r[1]) +
                                 64'(item_ff[s-1].prd_r[2]);
            item_in[s].sq[1].n = 64'(item_ff[s-1].prd_v[0]) + 64'(item_ff[s-1].prd_v[1]) +
                                 64'(item_ff[s-1].prd_v[2]);
            item_in[s].sq[0].root = '0;
            item_in[s].sq[1].root = '0;
         end
      end else if (s >= ST_RT0 && s < ST_DIV0) begin : g_rt
         // lengths of the normalized r and v, one root bit per stage
         localparam logic [63:0] BITV = 64'd1 << (62 - 2 * (s - ST_RT0));
         always_comb begin
            item_in[s]       = item_ff[s-1];
            item_in[s].sq[0] = cmvk_pkg::sqrt_step(item_ff[s-1].sq[0], BITV);
            item_in[s].sq[1] = cmvk_pkg::sqrt_step(item_ff[s-1].sq[1], BITV);
         end
      end else if (s == ST_DIV0) begin : g_div0
         always_comb begin
            item_in[s] = item_ff[s-1];
            for (int i = 0; i < 3; i++) begin
               item_in[s].urem_r[i] = {1'b0, cmvk_pkg::abs32(item_ff[s-1].a_r[i])};
               item_in[s].urem_v[i] = {1'b0, cmvk_pkg::abs32(item_ff[s-1].a_v[i])};
               item_in[s].uq_r[i]   = '0;
               item_in[s].uq_v[i]   = '0;
            end
            item_in[s].mrem = {2'b00, central_mass_ff};
            item_in[s].mq   = '0;
         end
      end else if (s >= ST_DS0 && s < ST_SGN) begin : g_ds
         // unit vectors (first 31 steps) and mass / |r|, one bit per stage
         localparam int J = s - ST_DS0;
         always_comb begin
            cmvk_pkg::div_type dr, dv, dm;
            item_in[s] = item_ff[s-1];
            if (J < cmvk_pkg::UDIV_STEPS) begin
               for (int i = 0; i < 3; i++) begin
                  dr = cmvk_pkg::div_step(item_ff[s-1].urem_r[i],
                                          item_ff[s-1].sq[0].root[31:0]);
                  dv = cmvk_pkg::div_step(item_ff[s-1].urem_v[i],
                                          item_ff[s-1].sq[1].root[31:0]);
                  item_in[s].urem_r[i] = dr.rem;
                  item_in[s].urem_v[i] = dv.rem;
                  item_in[s].uq_r[i]   = {item_ff[s-1].uq_r[i][29:0], dr.qb};
                  item_in[s].uq_v[i]   = {item_ff[s-1].uq_v[i][29:0], dv.qb};
               end
            end
            dm = cmvk_pkg::div_step(item_ff[s-1].mrem, item_ff[s-1].sq[0].root[31:0]);
            item_in[s].mrem = dm.rem;
            item_in[s].mq   = {item_ff[s-1].mq[QX-2:0], dm.qb};
         end
      end else if (s == ST_SGN) begin : g_sgn
         // signed unit vectors; mass quotient scaled by 2^-(30-k_r), saturated
         always_comb begin
            logic [QX-1:0]     sh;
            logic [5:0]        d;
            logic signed [31:0] mr, mv;
            item_in[s] = item_ff[s-1];
            for (int i = 0; i < 3; i++) begin
               mr = $signed({1'b0, item_ff[s-1].uq_r[i]});
               mv = $signed({1'b0, item_ff[s-1].uq_v[i]});
               item_in[s].rh[i] = item_ff[s-1].a_r[i][31] ? -mr : mr;
               item_in[s].vh[i] = item_ff[s-1].a_v[i][31] ? -mv : mv;
            end
            d  = 6'(6'sd30 - item_ff[s-1].k_r);
            sh = item_ff[s-1].mq >> d[4:0];
            item_in[s].q = (|sh[QX-1:64]) ? '1 : sh[63:0];
         end
      end else if (s == ST_DP) begin : g_dp
         always_comb begin
            item_in[s] = item_ff[s-1];
            for (int i = 0; i < 3; i++) begin
               item_in[s].prd_r[i] = 65'(item_ff[s-1].rh[i]) * 65'(item_ff[s-1].vh[i]);
            end
         end
      end else if (s == ST_DOT) begin : g_dot
         always_comb begin
            logic signed [66:0] sum;
            item_in[s] = item_ff[s-1];
            sum = 67'(item_ff[s-1].prd_r[0]) + 67'(item_ff[s-1].prd_r[1]) +
                  67'(item_ff[s-1].prd_r[2]);
            item_in[s].dot = $signed(sum[cmvk_pkg::Q30+31:cmvk_pkg::Q30]);
         end
      end else if (s == ST_RD) begin : g_rd
         always_comb begin
            item_in[s] = item_ff[s-1];
            for (int i = 0; i < 3; i++) begin
               item_in[s].prd_r[i] = 65'(item_ff[s-1].rh[i]) * 65'(item_ff[s-1].dot);
            end
         end
      end else if (s == ST_U) begin : g_u
         // perpendicular part of v, clamped to +-1.0 in Q30
         always_comb begin
            logic signed [34:0] t;
            logic signed [35:0] uw;
            item_in[s] = item_ff[s-1];
            for (int i = 0; i < 3; i++) begin
               t  = $signed(item_ff[s-1].prd_r[i][64:cmvk_pkg::Q30]);
               uw = 36'(item_ff[s-1].vh[i]) - 36'(t);
               if (uw > 36'sd1073741824) begin
                  item_in[s].u[i] = 32'sd1073741824;
               end else if (uw < -36'sd1073741824) begin
                  item_in[s].u[i] = -32'sd1073741824;
               end else begin
                  item_in[s].u[i] = uw[31:0];
               end
            end
         end
      end else if (s == ST_QI) begin : g_qi
         always_comb begin
            item_in[s]            = item_ff[s-1];
            item_in[s].sq[0].n    = item_ff[s-1].q;
            item_in[s].sq[0].root = '0;
         end
      end else if (s >= ST_QS0 && s < ST_KM) begin : g_qs
         // speed factor sqrt(q), one bit per stage
         localparam logic [63:0] BITV = 64'd1 << (62 - 2 * (s - ST_QS0));
         always_comb begin
            item_in[s]       = item_ff[s-1];
            item_in[s].sq[0] = cmvk_pkg::sqrt_step(item_ff[s-1].sq[0], BITV);
         end
      end else begin : g_km
         // kick products u * s
         always_comb begin
            item_in[s] = item_ff[s-1];
            for (int i = 0; i < 3; i++) begin
               item_in[s].prd_v[i] = 65'(item_ff[s-1].u[i]) *
                                     65'($signed({1'b0, item_ff[s-1].sq[0].root[31:0]}));
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            item_ff[s] <= item_in[s];
         end
      end
   end

   // ---------------- final add, saturation and response register ----------------
   always_comb begin
      logic signed [34:0] kick;
      logic signed [35:0] tot;
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         kick = $signed(item_ff[NS-1].prd_v[i][64:cmvk_pkg::Q30]);
         tot  = add_mode_ff ? 36'(item_ff[NS-1].vel[i]) + 36'(kick) : 36'(kick);
         if (tot > 36'sd2147483647) begin
            res_in[i] = 32'sh7fffffff;
            sat_in    = 1'b1;
         end else if (tot < -36'sd2147483648) begin
            res_in[i] = 32'sh80000000;
            sat_in    = 1'b1;
         end else begin
            res_in[i] = tot[31:0];
         end
      end
      if (item_ff[NS-1].degen) begin
         for (int i = 0; i < 3; i++) begin
            res_in[i] = item_ff[NS-1].vel[i];
         end
         sat_in = 1'b0;
      end
      degen_in = item_ff[NS-1].degen;
      last_in  = item_ff[NS-1].last;
   end

   assign load         = vld_ff[NS-1] && adv;
   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff   <= res_in;
         degen_ff <= degen_in;
         sat_ff   <= sat_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_vel_x  = res_ff[0];
   assign rsp_new_vel_y  = res_ff[1];
   assign rsp_new_vel_z  = res_ff[2];
   assign rsp_degenerate = degen_ff;
   assign rsp_saturated  = sat_ff;
   assign rsp_last_out   = last_ff;

   // ---------------- assertions ----------------
   `ASSERT_ON_CLK(a_stall_cause, clock, reset, !adv |-> (vld_ff[NS-1] && rsp_valid_ff && !rsp_ready), "pipe held without a blocked response")
   `ASSERT_ON_CLK(a_tail_load, clock, reset, (vld_ff[NS-1] && adv) |=> rsp_valid_ff, "finished request did not reach the response register")
   `ASSERT_NEVER(a_degen_sat, clock, reset, rsp_valid_ff && rsp_degenerate && rsp_saturated, "degenerate response flagged as saturated")

endmodule
